/* hw/rtl/cau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  // per-item flags that travel with the divider data
  typedef struct packed {
    mode_e mode;
    logic  dz;   // divisor magnitude is zero
    logic  sx;   // sign of real numerator
    logic  sy;   // sign of imag numerator
    logic  ox;   // real quotient does not fit
    logic  oy;   // imag quotient does not fit
  } div_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/cau_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cau_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;

  modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cau_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface cau_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_real;
  logic signed [DATA_WIDTH-1:0] r_imag;
  logic [1:0]                   status;

  modport source (output valid, r_real, r_imag, status, input ready);
  modport sink (input valid, r_real, r_imag, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cau_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_mul #(
  parameter int W = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic signed [W-1:0]   ar_i,
  input  wire logic signed [W-1:0]   ai_i,
  input  wire logic signed [W-1:0]   br_i,
  input  wire logic signed [W-1:0]   bi_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [1:0]                 mode_o,
  output logic signed [W-1:0]        ar_o,
  output logic signed [W-1:0]        ai_o,
  output logic signed [W-1:0]        br_o,
  output logic signed [W-1:0]        bi_o,
  output logic signed [2*W-1:0]      p0_o,
  output logic signed [2*W-1:0]      p1_o,
  output logic signed [2*W-1:0]      p2_o,
  output logic signed [2*W-1:0]      p3_o,
  output logic signed [2*W-1:0]      p4_o,
  output logic signed [2*W-1:0]      p5_o
);
  localparam int PW = 2 * W;

  logic valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mode_o <= mode_i;
      ar_o   <= ar_i;
      ai_o   <= ai_i;
      br_o   <= br_i;
      bi_o   <= bi_i;
      p0_o   <= PW'(ar_i) * PW'(br_i);
      p1_o   <= PW'(ai_i) * PW'(bi_i);
      p2_o   <= PW'(ar_i) * PW'(bi_i);
      p3_o   <= PW'(ai_i) * PW'(br_i);
      p4_o   <= PW'(br_i) * PW'(br_i);
      p5_o   <= PW'(bi_i) * PW'(bi_i);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cau_sum.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_sum #(
  parameter int W = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic signed [W-1:0]   ar_i,
  input  wire logic signed [W-1:0]   ai_i,
  input  wire logic signed [W-1:0]   br_i,
  input  wire logic signed [W-1:0]   bi_i,
  input  wire logic signed [2*W-1:0] p0_i,
  input  wire logic signed [2*W-1:0] p1_i,
  input  wire logic signed [2*W-1:0] p2_i,
  input  wire logic signed [2*W-1:0] p3_i,
  input  wire logic signed [2*W-1:0] p4_i,
  input  wire logic signed [2*W-1:0] p5_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [1:0]                 mode_o,
  output logic signed [2*W:0]        x_o,
  output logic signed [2*W:0]        y_o,
  output logic [2*W-1:0]             m_o
);
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;

  logic                 valid_q;
  logic signed [SW-1:0] x_d;
  logic signed [SW-1:0] y_d;
  logic signed [SW-1:0] m_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    m_d = SW'(p4_i) + SW'(p5_i);
    case (cau_pkg::mode_e'(mode_i))
      cau_pkg::MODE_ADD: begin
        x_d = SW'(ar_i) + SW'(br_i);
        y_d = SW'(ai_i) + SW'(bi_i);
      end
      cau_pkg::MODE_SUB: begin
        x_d = SW'(ar_i) - SW'(br_i);
        y_d = SW'(ai_i) - SW'(bi_i);
      end
      cau_pkg::MODE_MUL: begin
        x_d = SW'(p0_i) - SW'(p1_i);
        y_d = SW'(p2_i) + SW'(p3_i);
      end
      default: begin
        // a * conj(b)
        x_d = SW'(p0_i) + SW'(p1_i);
        y_d = SW'(p3_i) - SW'(p2_i);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mode_o <= mode_i;
      x_o    <= x_d;
      y_o    <= y_d;
      m_o    <= m_d[PW-1:0];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cau_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_prep #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic signed [2*W:0]         x_i,
  input  wire logic signed [2*W:0]         y_i,
  input  wire logic [2*W-1:0]              m_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output cau_pkg::div_ctl_t                ctl_o,
  output logic [3*W+F+1:0]                 rx_o,
  output logic [3*W+F+1:0]                 ry_o,
  output logic [2*W-1:0]                   m_o,
  output logic [W-1:0]                     qx_o,
  output logic [W-1:0]                     qy_o
);
  localparam int SW = 2 * W + 1;
  localparam int RW = 3 * W + F + 2;

  logic              valid_q;
  logic              is_div;
  logic [SW-1:0]     mx;
  logic [SW-1:0]     my;
  logic [RW-1:0]     nx;
  logic [RW-1:0]     ny;
  logic [RW-1:0]     dtop;
  cau_pkg::div_ctl_t ctl_d;
  logic [RW-1:0]     rx_d;
  logic [RW-1:0]     ry_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    is_div     = (cau_pkg::mode_e'(mode_i) == cau_pkg::MODE_DIV);
    mx         = x_i[SW-1] ? SW'(-x_i) : SW'(x_i);
    my         = y_i[SW-1] ? SW'(-y_i) : SW'(y_i);
    nx         = RW'(mx) << F;
    ny         = RW'(my) << F;
    dtop       = RW'(m_i) << W;
    ctl_d.mode = cau_pkg::mode_e'(mode_i);
    ctl_d.dz   = (m_i == '0);
    ctl_d.sx   = x_i[SW-1];
    ctl_d.sy   = y_i[SW-1];
    // quotient of 2^W or more saturates anyway
    ctl_d.ox   = (nx >= dtop);
    ctl_d.oy   = (ny >= dtop);
    rx_d       = is_div ? nx : RW'(x_i);
    ry_d       = is_div ? ny : RW'(y_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_o <= ctl_d;
      rx_o  <= rx_d;
      ry_o  <= ry_d;
      m_o   <= m_i;
      qx_o  <= '0;
      qy_o  <= '0;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cau_div_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_div_step #(
  parameter int W = 32,
  parameter int F = 16,
  parameter int K = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire cau_pkg::div_ctl_t   ctl_i,
  input  wire logic [3*W+F+1:0]    rx_i,
  input  wire logic [3*W+F+1:0]    ry_i,
  input  wire logic [2*W-1:0]      m_i,
  input  wire logic [W-1:0]        qx_i,
  input  wire logic [W-1:0]        qy_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output cau_pkg::div_ctl_t        ctl_o,
  output logic [3*W+F+1:0]         rx_o,
  output logic [3*W+F+1:0]         ry_o,
  output logic [2*W-1:0]           m_o,
  output logic [W-1:0]             qx_o,
  output logic [W-1:0]             qy_o
);
  localparam int RW = 3 * W + F + 2;

  logic          valid_q;
  logic          is_div;
  logic [RW-1:0] dsh;
  logic          gx;
  logic          gy;
  logic [RW-1:0] rx_d;
  logic [RW-1:0] ry_d;
  logic [W-1:0]  qx_d;
  logic [W-1:0]  qy_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  // one restoring quotient bit per stage, real and imag side by side
  always_comb begin
    is_div = (ctl_i.mode == cau_pkg::MODE_DIV);
    dsh    = RW'(m_i) << K;
    gx     = is_div && (rx_i >= dsh);
    gy     = is_div && (ry_i >= dsh);
    rx_d   = gx ? rx_i - dsh : rx_i;
    ry_d   = gy ? ry_i - dsh : ry_i;
    qx_d   = qx_i;
    qy_d   = qy_i;
    qx_d[K] = gx;
    qy_d[K] = gy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ctl_o <= ctl_i;
      rx_o  <= rx_d;
      ry_o  <= ry_d;
      m_o   <= m_i;
      qx_o  <= qx_d;
      qy_o  <= qy_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/cau_sat.sv */
`timescale 1ns / 1ps
`default_nettype none
module cau_sat #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cau_pkg::div_ctl_t ctl_i,
  input  wire logic [3*W+F+1:0]  rx_i,
  input  wire logic [3*W+F+1:0]  ry_i,
  input  wire logic [W-1:0]      qx_i,
  input  wire logic [W-1:0]      qy_i,
  cau_out_if.source              out_o
);
  localparam int SW = 2 * W + 1;
  localparam int RW = 3 * W + F + 2;
  localparam logic [SW-1:0] BIAS = (SW'(1) << F) - SW'(1);
  localparam logic [SW-1:0] BIG  = SW'(1) << W;
  localparam logic [SW-1:0] MAXV = (SW'(1) << (W - 1)) - SW'(1);
  localparam logic [SW-1:0] MINV = SW'(0) - (SW'(1) << (W - 1));

  logic                 valid_q;
  logic signed [SW-1:0] vx;
  logic signed [SW-1:0] vy;
  logic                 ovx;
  logic                 ovy;
  logic [W-1:0]         rr_d;
  logic [W-1:0]         ri_d;
  cau_pkg::status_e     st_d;

  function automatic logic signed [SW-1:0] part_val(
    input logic [RW-1:0]  r,
    input logic [W-1:0]   q,
    input logic           s,
    input logic           o,
    input cau_pkg::mode_e md
  );
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] v;
    x = $signed(r[SW-1:0]);
    case (md)
      cau_pkg::MODE_MUL: begin
        // round toward zero
        v = (x + (x[SW-1] ? $signed(BIAS) : $signed(SW'(0)))) >>> F;
      end
      cau_pkg::MODE_DIV: begin
        if (o) begin
          v = s ? -$signed(BIG) : $signed(BIG);
        end else begin
          v = s ? -$signed(SW'(q)) : $signed(SW'(q));
        end
      end
      default: v = x;
    endcase
    return v;
  endfunction

  assign ready_o   = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;

  always_comb begin
    vx  = part_val(rx_i, qx_i, ctl_i.sx, ctl_i.ox, ctl_i.mode);
    vy  = part_val(ry_i, qy_i, ctl_i.sy, ctl_i.oy, ctl_i.mode);
    ovx = (vx > $signed(MAXV)) || (vx < $signed(MINV));
    ovy = (vy > $signed(MAXV)) || (vy < $signed(MINV));
    if (vx > $signed(MAXV)) begin
      rr_d = MAXV[W-1:0];
    end else if (vx < $signed(MINV)) begin
      rr_d = MINV[W-1:0];
    end else begin
      rr_d = vx[W-1:0];
    end
    if (vy > $signed(MAXV)) begin
      ri_d = MAXV[W-1:0];
    end else if (vy < $signed(MINV)) begin
      ri_d = MINV[W-1:0];
    end else begin
      ri_d = vy[W-1:0];
    end
    st_d = (ovx || ovy) ? cau_pkg::STATUS_OVERFLOW : cau_pkg::STATUS_OK;
    if (ctl_i.mode == cau_pkg::MODE_DIV && ctl_i.dz) begin
      rr_d = '0;
      ri_d = '0;
      st_d = cau_pkg::STATUS_DIV_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      out_o.r_real <= rr_d;
      out_o.r_imag <= ri_d;
      out_o.status <= st_d;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/complex_arithmetic_unit.sv */
// Complex add, subtract, multiply and divide on signed fixed point operands
// (DATA_WIDTH bits, FRAC_BITS fraction bits). One item can enter every cycle
// while the output is accepted; each item passes DATA_WIDTH + 4 register
// stages on its way to the output: one stage of multipliers, one of sums,
// one of divide setup, one restoring divider stage per quotient bit
// (DATA_WIDTH of them), and the saturating output register.
// Every stage holds its own valid bit and fills bubbles, so the input keeps
// being taken while a result waits at the output, until every stage behind
// it is full. Multiply and divide truncate toward zero; a zero divisor gives
// zero with status 1, and a clamped part gives status 2.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int RW = 3 * W + F + 2;

  logic                 m_valid;
  logic                 m_ready;
  logic [1:0]           m_mode;
  logic signed [W-1:0]  m_ar;
  logic signed [W-1:0]  m_ai;
  logic signed [W-1:0]  m_br;
  logic signed [W-1:0]  m_bi;
  logic signed [PW-1:0] m_p0;
  logic signed [PW-1:0] m_p1;
  logic signed [PW-1:0] m_p2;
  logic signed [PW-1:0] m_p3;
  logic signed [PW-1:0] m_p4;
  logic signed [PW-1:0] m_p5;

  logic                 s_valid;
  logic                 s_ready;
  logic [1:0]           s_mode;
  logic signed [SW-1:0] s_x;
  logic signed [SW-1:0] s_y;
  logic [PW-1:0]        s_m;

  logic              d_valid [W+1];
  logic              d_ready [W+1];
  cau_pkg::div_ctl_t d_ctl   [W+1];
  logic [RW-1:0]     d_rx    [W+1];
  logic [RW-1:0]     d_ry    [W+1];
  logic [PW-1:0]     d_m     [W+1];
  logic [W-1:0]      d_qx    [W+1];
  logic [W-1:0]      d_qy    [W+1];

  cau_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_i.mode),
    .ar_i    (in_i.a_real),
    .ai_i    (in_i.a_imag),
    .br_i    (in_i.b_real),
    .bi_i    (in_i.b_imag),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .mode_o  (m_mode),
    .ar_o    (m_ar),
    .ai_o    (m_ai),
    .br_o    (m_br),
    .bi_o    (m_bi),
    .p0_o    (m_p0),
    .p1_o    (m_p1),
    .p2_o    (m_p2),
    .p3_o    (m_p3),
    .p4_o    (m_p4),
    .p5_o    (m_p5)
  );

  cau_sum #(.W(W)) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .mode_i  (m_mode),
    .ar_i    (m_ar),
    .ai_i    (m_ai),
    .br_i    (m_br),
    .bi_i    (m_bi),
    .p0_i    (m_p0),
    .p1_i    (m_p1),
    .p2_i    (m_p2),
    .p3_i    (m_p3),
    .p4_i    (m_p4),
    .p5_i    (m_p5),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .mode_o  (s_mode),
    .x_o     (s_x),
    .y_o     (s_y),
    .m_o     (s_m)
  );

  cau_prep #(.W(W), .F(F)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .mode_i  (s_mode),
    .x_i     (s_x),
    .y_i     (s_y),
    .m_i     (s_m),
    .valid_o (d_valid[0]),
    .ready_i (d_ready[0]),
    .ctl_o   (d_ctl[0]),
    .rx_o    (d_rx[0]),
    .ry_o    (d_ry[0]),
    .m_o     (d_m[0]),
    .qx_o    (d_qx[0]),
    .qy_o    (d_qy[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_step #(.W(W), .F(F), .K(W - 1 - i)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_valid[i]),
      .ready_o (d_ready[i]),
      .ctl_i   (d_ctl[i]),
      .rx_i    (d_rx[i]),
      .ry_i    (d_ry[i]),
      .m_i     (d_m[i]),
      .qx_i    (d_qx[i]),
      .qy_i    (d_qy[i]),
      .valid_o (d_valid[i+1]),
      .ready_i (d_ready[i+1]),
      .ctl_o   (d_ctl[i+1]),
      .rx_o    (d_rx[i+1]),
      .ry_o    (d_ry[i+1]),
      .m_o     (d_m[i+1]),
      .qx_o    (d_qx[i+1]),
      .qy_o    (d_qy[i+1])
    );
  end

  cau_sat #(.W(W), .F(F)) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid[W]),
    .ready_o (d_ready[W]),
    .ctl_i   (d_ctl[W]),
    .rx_i    (d_rx[W]),
    .ry_i    (d_ry[W]),
    .qx_i    (d_qx[W]),
    .qy_i    (d_qy[W]),
    .out_o   (out_o)
  );
endmodule
`default_nettype wire

/* tb/sv/complex_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1800;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    cau_pkg::mode_e mode;
    logic signed [DW-1:0] ar, ai, br, bi;
    bit drain;  // hold this item until the pipeline is empty
  } operands_t;

  typedef struct {
    logic signed [DW-1:0] re, im;
    cau_pkg::status_e status;
  } cresult_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cau_in_if #(.DATA_WIDTH(DW)) in_if ();
  cau_out_if #(.DATA_WIDTH(DW)) out_if ();

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  operands_t pending_q[$];
  cresult_t  expected_q[$];
  int        n_err = 0;
  int        n_checked = 0;
  int        mode_cnt[4];
  int        status_cnt[3];

  function automatic wide_t trunc_shr(wide_t v);
    if (v < 0) return -((-v) >>> FB);
    return v >>> FB;
  endfunction

  function automatic logic signed [DW-1:0] clamp(wide_t v, ref bit ovf);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (DW - 1)) - 1;
    lo = -(wide_t'(1) <<< (DW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic cresult_t complex_result(operands_t op);
    cresult_t r;
    wide_t ar, ai, br, bi, x, y, mag2;
    bit ovf;
    ar = op.ar;
    ai = op.ai;
    br = op.br;
    bi = op.bi;
    ovf = 1'b0;
    case (op.mode)
      cau_pkg::MODE_ADD: begin
        x = ar + br;
        y = ai + bi;
      end
      cau_pkg::MODE_SUB: begin
        x = ar - br;
        y = ai - bi;
      end
      cau_pkg::MODE_MUL: begin
        x = trunc_shr(ar * br - ai * bi);
        y = trunc_shr(ar * bi + ai * br);
      end
      default: begin
        mag2 = br * br + bi * bi;
        if (mag2 == 0) begin
          r.re = '0;
          r.im = '0;
          r.status = cau_pkg::STATUS_DIV_ZERO;
          return r;
        end
        // signed divide truncates toward zero
        x = ((ar * br + ai * bi) <<< FB) / mag2;
        y = ((ai * br - ar * bi) <<< FB) / mag2;
      end
    endcase
    r.re = clamp(x, ovf);
    r.im = clamp(y, ovf);
    r.status = ovf ? cau_pkg::STATUS_OVERFLOW : cau_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] rand_part(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  task automatic add_op(cau_pkg::mode_e m, int ar, int ai, int br, int bi,
                        bit drain = 1'b0);
    operands_t op;
    op.mode = m;
    op.ar = ar;
    op.ai = ai;
    op.br = br;
    op.bi = bi;
    op.drain = drain;
    pending_q.push_back(op);
  endtask

  // driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    operands_t op;
    cresult_t res;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        op.mode = cau_pkg::mode_e'(in_if.mode);
        op.ar = in_if.a_real;
        op.ai = in_if.a_imag;
        op.br = in_if.b_real;
        op.bi = in_if.b_imag;
        res = complex_result(op);
        expected_q.push_back(res);
        mode_cnt[op.mode]++;
        status_cnt[res.status]++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && expected_q.size() > 0)) begin
          op = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode <= op.mode;
          in_if.a_real <= op.ar;
          in_if.a_imag <= op.ai;
          in_if.b_real <= op.br;
          in_if.b_imag <= op.bi;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end else begin
      in_if.valid <= 1'b0;
      in_if.mode <= '0;
      in_if.a_real <= '0;
      in_if.a_imag <= '0;
      in_if.b_real <= '0;
      in_if.b_imag <= '0;
    end
  end

  // monitor: receiver stall pattern changes every window
  int window_left = 0;
  int ready_pct = 100;
  always @(posedge clk_i) begin
    cresult_t exp_r;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h status=%0d", $time,
                   out_if.r_real, out_if.r_imag, out_if.status);
          n_err++;
        end else begin
          exp_r = expected_q.pop_front();
          n_checked++;
          if (out_if.r_real !== exp_r.re) begin
            $display("%0t: r_real expected %h actual %h", $time, exp_r.re, out_if.r_real);
            n_err++;
          end
          if (out_if.r_imag !== exp_r.im) begin
            $display("%0t: r_imag expected %h actual %h", $time, exp_r.im, out_if.r_imag);
            n_err++;
          end
          if (out_if.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_if.status);
            n_err++;
          end
        end
      end
      if (window_left == 0) begin
        window_left <= $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 70;
          2: ready_pct <= 30;
          default: ready_pct <= 5;
        endcase
      end else begin
        window_left <= window_left - 1;
      end
      out_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  initial begin
    operands_t op;
    int kind;

    // directed: extremes, zero divisor, overflow, negative truncation
    add_op(cau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_op(cau_pkg::MODE_ADD, 32'h0001_0000, -32'sh0002_0000, 32'h0000_8000, 32'h0003_0000);
    add_op(cau_pkg::MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    add_op(cau_pkg::MODE_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
    add_op(cau_pkg::MODE_SUB, 32'h1234_5678, -32'sh0000_1234, 32'h1234_5678, 32'h0000_0001);
    add_op(cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_op(cau_pkg::MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_op(cau_pkg::MODE_MUL, -32'sh0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    add_op(cau_pkg::MODE_MUL, 32'h0002_0000, 32'h0001_8000, -32'sh0000_c000, 32'h0000_4000);
    add_op(cau_pkg::MODE_MUL, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0003_0000);
    add_op(cau_pkg::MODE_DIV, -32'sh0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
    add_op(cau_pkg::MODE_DIV, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, -32'sh0000_0001);
    add_op(cau_pkg::MODE_DIV, 32'h0002_0000, -32'sh0001_0000, 32'h0001_0000, 32'h0001_0000,
           1'b1);
    add_op(cau_pkg::MODE_MUL, 32'h0000_ffff, -32'sh0000_ffff, 32'h0000_ffff, 32'h0000_ffff);

    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 3);
      op.mode = cau_pkg::mode_e'($urandom_range(0, 3));
      op.ar = rand_part(kind);
      op.ai = rand_part(kind);
      op.br = rand_part(($urandom_range(0, 4) == 0) ? 0 : kind);
      op.bi = rand_part(kind);
      if (op.mode == cau_pkg::MODE_DIV && $urandom_range(0, 15) == 0) begin
        op.br = '0;
        op.bi = '0;
      end
      op.drain = (i % 600 == 300);
      pending_q.push_back(op);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !in_if.valid);
    wait (expected_q.size() == 0);
    repeat (DW + 40) @(posedge clk_i);
    $display("Checked %0d results; add/sub/mul/div items: %0d/%0d/%0d/%0d", n_checked,
             mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
    $display("Expected status counts: ok %0d, divide by zero %0d, saturated %0d",
             status_cnt[0], status_cnt[1], status_cnt[2]);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cau_pkg.sv
hw/rtl/cau_in_if.sv
hw/rtl/cau_out_if.sv
hw/rtl/cau_mul.sv
hw/rtl/cau_sum.sv
hw/rtl/cau_prep.sv
hw/rtl/cau_div_step.sv
hw/rtl/cau_sat.sv
hw/rtl/complex_arithmetic_unit.sv
tb/sv/complex_arithmetic_unit_tb.sv
